FILE: src/tcw_pkg.sv
// tcw_pkg: shared constants and types for the text console writer
// request and escape codes, control characters, controller/datapath structs
// no dependencies
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 24;

    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_CURSOR = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [1:0] ESC_NONE      = 2'd0;
    localparam logic [1:0] ESC_ATTR_WAIT = 2'd1;
    localparam logic [1:0] ESC_FG_WAIT   = 2'd2;
    localparam logic [1:0] ESC_BG_WAIT   = 2'd3;

    localparam logic [7:0] CH_ESC_ATTR = 8'h11;
    localparam logic [7:0] CH_ESC_FG   = 8'h12;
    localparam logic [7:0] CH_ESC_BG   = 8'h13;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_BLANK    = 8'h20;
    localparam logic [7:0] ATTR_RESET  = 8'h07;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef struct packed {
        logic accept;
        logic copy_step;
        logic fill_step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic scroll;
        logic clear;
        logic wr_busy;
        logic sweep_last;
    } t_status;

endpackage

`default_nettype wire

FILE: src/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine of the text console writer
// handles the channel handshakes and steps the datapath sweeps
// depends on tcw_pkg
`default_nettype none

module tcw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_stall,
    input  wire tcw_pkg::t_status i_status,
    output tcw_pkg::t_cmd        o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_COPY = 5'b00100,
        S_FILL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_INIT: begin
                cmd.fill_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !i_status.wr_busy) begin
                    cmd.accept = 1'b1;
                    if (i_status.scroll) begin
                        n_state = S_COPY;
                    end else if (i_status.clear) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COPY: begin
                cmd.copy_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE) || i_status.wr_busy;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: src/tcw_dpath.sv
// tcw_dpath: cell buffer, cursor, attribute and escape registers
// runs put/cursor/clear/read updates, scroll copy and blank fill sweeps
// depends on tcw_pkg
`default_nettype none

module tcw_dpath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tcw_pkg::t_cmd    i_cmd,
    output tcw_pkg::t_status      o_status,
    input  wire logic [1:0]       i_req_type,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [7:0]       i_pos_x,
    input  wire logic [7:0]       i_pos_y,
    input  wire logic [10:0]      i_cell_index,
    output logic [7:0]            o_cell_char,
    output logic [7:0]            o_cell_attr,
    output logic [6:0]            o_cursor_col,
    output logic [4:0]            o_cursor_row,
    output logic [7:0]            o_current_attribute,
    output logic [1:0]            o_escape_mode
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW    = $clog2(ROWS);
    localparam int IW    = ((AW > 11) ? AW : 11) + 1;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_BASE  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] FIRST_SRC = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    logic [15:0]   r_mem [CELLS];

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [7:0]    r_attr;
    logic [1:0]    r_esc;
    logic [AW-1:0] r_sweep;
    logic          r_wr_en;
    logic          r_wr_copy;
    logic [AW-1:0] r_wr_addr;
    logic [15:0]   r_wr_data;
    logic [15:0]   r_rd_data;
    logic          r_rd_ok;
    logic [7:0]    r_cell_char;
    logic [7:0]    r_cell_attr;
    logic [6:0]    r_cursor_col;
    logic [4:0]    r_cursor_row;
    logic [7:0]    r_cur_attr;
    logic [1:0]    r_esc_mode;

    logic          is_put;
    logic          is_special;
    logic          at_last_col;
    logic          at_last_row;
    logic          put_plain;
    logic          put_lf;
    logic          scroll;
    logic [AW-1:0] cur_addr;
    logic [IW-1:0] ci_ext;
    logic          rd_in_range;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          bypass;

    assign is_put      = (i_req_type == REQ_PUT) && (r_esc == ESC_NONE);
    assign is_special  = (i_data_byte == CH_ESC_ATTR) || (i_data_byte == CH_ESC_FG) ||
                         (i_data_byte == CH_ESC_BG) || (i_data_byte == CH_CR) ||
                         (i_data_byte == CH_LF);
    assign at_last_col = (r_col == LAST_COL);
    assign at_last_row = (r_row == LAST_ROW);
    assign put_plain   = is_put && !is_special;
    assign put_lf      = is_put && (i_data_byte == CH_LF);
    assign scroll      = at_last_row && (put_lf || (put_plain && at_last_col));
    assign cur_addr    = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign ci_ext      = IW'(i_cell_index);
    assign rd_in_range = ci_ext < IW'(CELLS);
    assign rd_addr     = i_cmd.copy_step ? r_sweep : ci_ext[AW-1:0];
    assign rd_en       = i_cmd.accept || i_cmd.copy_step;
    assign bypass      = r_wr_en && !r_wr_copy && (r_wr_addr == rd_addr);

    assign o_status.scroll     = scroll;
    assign o_status.clear      = (i_req_type == REQ_CLEAR);
    assign o_status.wr_busy    = r_wr_en;
    assign o_status.sweep_last = (r_sweep == LAST_CELL);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_attr  <= ATTR_RESET;
            r_esc   <= ESC_NONE;
            r_sweep <= '0;
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= (i_cmd.accept && put_plain) || i_cmd.copy_step || i_cmd.fill_step;
            if (i_cmd.accept) begin
                unique case (i_req_type)
                    REQ_PUT: begin
                        unique case (r_esc)
                            ESC_ATTR_WAIT: begin
                                r_attr <= i_data_byte;
                                r_esc  <= ESC_NONE;
                            end
                            ESC_FG_WAIT: begin
                                r_attr <= {r_attr[7:4], i_data_byte[3:0] & NIBBLE_MASK};
                                r_esc  <= ESC_NONE;
                            end
                            ESC_BG_WAIT: begin
                                r_attr <= {i_data_byte[3:0] & NIBBLE_MASK, r_attr[3:0]};
                                r_esc  <= ESC_NONE;
                            end
                            ESC_NONE: begin
                                if (i_data_byte == CH_ESC_ATTR) begin
                                    r_esc <= ESC_ATTR_WAIT;
                                end else if (i_data_byte == CH_ESC_FG) begin
                                    r_esc <= ESC_FG_WAIT;
                                end else if (i_data_byte == CH_ESC_BG) begin
                                    r_esc <= ESC_BG_WAIT;
                                end else if (i_data_byte == CH_LF) begin
                                    r_col <= '0;
                                    if (!at_last_row) begin
                                        r_row <= r_row + RW'(1);
                                    end
                                end else if (i_data_byte != CH_CR) begin
                                    if (at_last_col) begin
                                        r_col <= '0;
                                        if (!at_last_row) begin
                                            r_row <= r_row + RW'(1);
                                        end
                                    end else begin
                                        r_col <= r_col + CW'(1);
                                    end
                                end
                            end
                            default: begin
                                r_esc <= ESC_NONE;
                            end
                        endcase
                        if (scroll) begin
                            r_sweep <= FIRST_SRC;
                        end
                    end
                    REQ_CURSOR: begin
                        if ({1'b0, i_pos_x} < 9'(COLUMNS)) begin
                            r_col <= i_pos_x[CW-1:0];
                        end
                        if (i_pos_y < 8'(ROWS)) begin
                            r_row <= i_pos_y[RW-1:0];
                        end
                    end
                    REQ_CLEAR: begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_sweep <= '0;
                    end
                    REQ_READ: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.copy_step) begin
                r_sweep <= (r_sweep == LAST_CELL) ? ROW_BASE : r_sweep + AW'(1);
            end
            if (i_cmd.fill_step) begin
                r_sweep <= r_sweep + AW'(1);
            end
        end
    end

    // staged write payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wr_copy <= 1'b0;
            r_wr_addr <= cur_addr;
            r_wr_data <= {r_attr, i_data_byte};
            r_rd_ok   <= (i_req_type == REQ_READ) && rd_in_range;
        end
        if (i_cmd.copy_step) begin
            r_wr_copy <= 1'b1;
            r_wr_addr <= r_sweep - FIRST_SRC;
        end
        if (i_cmd.fill_step) begin
            r_wr_copy <= 1'b0;
            r_wr_addr <= r_sweep;
            r_wr_data <= {r_attr, CH_BLANK};
        end
    end

    // cell buffer
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= r_wr_copy ? r_rd_data : r_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= bypass ? r_wr_data : r_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell_char  <= r_rd_ok ? r_rd_data[7:0] : 8'h00;
            r_cell_attr  <= r_rd_ok ? r_rd_data[15:8] : 8'h00;
            r_cursor_col <= 7'(r_col);
            r_cursor_row <= 5'(r_row);
            r_cur_attr   <= r_attr;
            r_esc_mode   <= r_esc;
        end
    end

    assign o_cell_char         = r_cell_char;
    assign o_cell_attr         = r_cell_attr;
    assign o_cursor_col        = r_cursor_col;
    assign o_cursor_row        = r_cursor_row;
    assign o_current_attribute = r_cur_attr;
    assign o_escape_mode       = r_esc_mode;

endmodule

`default_nettype wire

FILE: src/text_console_writer.sv
// text_console_writer: character-cell text console, top level
// joins tcw_ctrl and tcw_dpath; depends on tcw_pkg
//
// usage: one request item on the input channel (i_in_valid / o_in_stall) gives
// exactly one result item on the output channel (o_out_valid / i_out_stall)
// with the read cell (zero unless a read in range), cursor, attribute and
// escape mode after the request
// an ordinary request is accepted in S_IDLE and its result is registered from
// S_DONE; the next item is taken once tcw_ctrl is back in S_IDLE
// a request that scrolls walks the cell buffer once, copying rows up in S_COPY
// and blanking the last row in S_FILL; a clear blanks every cell in S_FILL
// after reset the buffer is filled with blanks in attribute 0x07, one cell
// per cycle, so o_in_stall stays high until the last blank is written
// while the receiver stalls, the finished result is held in the output
// register and the next item is still accepted and processed; its result
// waits until the register is taken
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [10:0] i_cell_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_attr,
    output logic [6:0]       o_cursor_col,
    output logic [4:0]       o_cursor_row,
    output logic [7:0]       o_current_attribute,
    output logic [1:0]       o_escape_mode
);
    import tcw_pkg::*;

    t_cmd    cmd;
    t_status status;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_req_type          (i_req_type),
        .i_data_byte         (i_data_byte),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_cell_index        (i_cell_index),
        .o_cell_char         (o_cell_char),
        .o_cell_attr         (o_cell_attr),
        .o_cursor_col        (o_cursor_col),
        .o_cursor_row        (o_cursor_row),
        .o_current_attribute (o_current_attribute),
        .o_escape_mode       (o_escape_mode)
    );

    // at most one item in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while previous one still in progress");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({27'd0, o_cursor_row} < ROWS))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({25'd0, o_cursor_col} < COLUMNS))
        else $error("cursor column out of range");

endmodule

`default_nettype wire

FILE: test/text_console_checker.sv
// text_console_checker: watches both channels of text_console_writer, predicts each result
// from its own model of the cell buffer, cursor, attribute and escape state, and compares
// depends on tcw_pkg
module text_console_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [10:0] i_cell_index,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_cell_char,
    input  wire logic [7:0]  i_cell_attr,
    input  wire logic [6:0]  i_cursor_col,
    input  wire logic [4:0]  i_cursor_row,
    input  wire logic [7:0]  i_current_attribute,
    input  wire logic [1:0]  i_escape_mode,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_scrolls
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] attribute;
        logic [1:0] escape_mode;
    } t_console_view;

    logic [15:0]   screen [CELLS];
    logic [6:0]    cur_col;
    logic [4:0]    cur_row;
    logic [7:0]    attr;
    logic [1:0]    esc;
    t_console_view view_q [$];
    t_console_view want;
    t_console_view got;

    function automatic void blank_screen(input logic [7:0] fill_attr);
        for (int i = 0; i < CELLS; i++) screen[i] = {fill_attr, CH_BLANK};
    endfunction

    function automatic void advance_line();
        cur_col = '0;
        if (cur_row >= ROWS - 1) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attr, CH_BLANK};
            cur_row = 5'(ROWS - 1);
            o_scrolls++;
        end else begin
            cur_row = cur_row + 5'd1;
        end
    endfunction

    function automatic void write_byte(input logic [7:0] b);
        case (esc)
            ESC_ATTR_WAIT: begin
                attr = b;
                esc  = ESC_NONE;
            end
            ESC_FG_WAIT: begin
                attr[3:0] = b[3:0] & NIBBLE_MASK;
                esc       = ESC_NONE;
            end
            ESC_BG_WAIT: begin
                attr[7:4] = b[3:0] & NIBBLE_MASK;
                esc       = ESC_NONE;
            end
            default: begin
                if (b == CH_ESC_ATTR) esc = ESC_ATTR_WAIT;
                else if (b == CH_ESC_FG) esc = ESC_FG_WAIT;
                else if (b == CH_ESC_BG) esc = ESC_BG_WAIT;
                else if (b == CH_LF) advance_line();
                else if (b != CH_CR) begin
                    screen[cur_row * COLUMNS + cur_col] = {attr, b};
                    cur_col = cur_col + 7'd1;
                    if (cur_col >= COLUMNS) advance_line();
                end
            end
        endcase
    endfunction

    function automatic t_console_view apply_request(input logic [1:0] rq, input logic [7:0] b,
                                                    input logic [7:0] x, input logic [7:0] y,
                                                    input logic [10:0] idx);
        t_console_view v;
        v = '0;
        case (rq)
            REQ_PUT: write_byte(b);
            REQ_CURSOR: begin
                if (x < COLUMNS) cur_col = x[6:0];
                if (y < ROWS) cur_row = y[4:0];
            end
            REQ_CLEAR: begin
                blank_screen(attr);
                cur_col = '0;
                cur_row = '0;
            end
            REQ_READ: begin
                if (idx < CELLS) {v.cell_attr, v.cell_char} = screen[idx];
            end
        endcase
        v.cursor_col  = cur_col;
        v.cursor_row  = cur_row;
        v.attribute   = attr;
        v.escape_mode = esc;
        return v;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val,
                     act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blank_screen(ATTR_RESET);
            cur_col = '0;
            cur_row = '0;
            attr    = ATTR_RESET;
            esc     = ESC_NONE;
            view_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                view_q.push_back(apply_request(i_req_type, i_data_byte, i_pos_x, i_pos_y,
                                               i_cell_index));
            if (i_out_valid && !i_out_stall) begin
                if (view_q.size() == 0) begin
                    $display("%0t: result item with nothing expected, got cursor %0d,%0d",
                             $time, i_cursor_col, i_cursor_row);
                    o_fail_count++;
                end else begin
                    want = view_q.pop_front();
                    got  = {i_cell_char, i_cell_attr, i_cursor_col, i_cursor_row,
                            i_current_attribute, i_escape_mode};
                    check_field("cell_char", int'(want.cell_char), int'(got.cell_char));
                    check_field("cell_attr", int'(want.cell_attr), int'(got.cell_attr));
                    check_field("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
                    check_field("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
                    check_field("current_attribute", int'(want.attribute),
                                int'(got.attribute));
                    check_field("escape_mode", int'(want.escape_mode),
                                int'(got.escape_mode));
                    o_checked++;
                end
            end
        end
        o_pending = view_q.size();
    end

endmodule

FILE: test/testbench.sv
// testbench: drives text_console_writer with directed then random request items, with
// random gaps and output stalls, and gives the verdict from text_console_checker
// depends on tcw_pkg, text_console_writer and text_console_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS = COLUMNS_DEF;
    localparam int ROWS    = ROWS_DEF;
    localparam int CELLS   = COLUMNS * ROWS;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  req_type  = REQ_PUT;
    logic [7:0]  data_byte = '0;
    logic [7:0]  pos_x     = '0;
    logic [7:0]  pos_y     = '0;
    logic [10:0] cell_index = '0;
    logic        out_stall = 1'b0;
    logic        in_taken  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  current_attribute;
    logic [1:0]  escape_mode;

    int fail_count;
    int pending;
    int checked;
    int scrolls;
    int req_count [4];
    int sent       = 0;
    int stall_hold = 0;
    bit calm       = 1'b0;

    text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_data_byte(data_byte), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_cell_index(cell_index),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_cell_char(cell_char), .o_cell_attr(cell_attr),
        .o_cursor_col(cursor_col), .o_cursor_row(cursor_row),
        .o_current_attribute(current_attribute), .o_escape_mode(escape_mode)
    );

    text_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_req_type(req_type), .i_data_byte(data_byte), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_cell_index(cell_index),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_cell_char(cell_char), .i_cell_attr(cell_attr),
        .i_cursor_col(cursor_col), .i_cursor_row(cursor_row),
        .i_current_attribute(current_attribute), .i_escape_mode(escape_mode),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked),
        .o_scrolls(scrolls)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) in_taken <= in_valid && !in_stall;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: stall-free runs, mostly short with some long ones, between mostly short stalls
    always @(negedge clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (out_stall) begin
            out_stall  <= 1'b0;
            stall_hold <= ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6)
                                                     : $urandom_range(20, 120);
        end else begin
            out_stall  <= 1'b1;
            stall_hold <= idle_len();
        end
    end

    task automatic send(input logic [1:0] rq, input logic [7:0] b, input logic [7:0] x,
                        input logic [7:0] y, input logic [10:0] idx);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        data_byte  <= b;
        pos_x      <= x;
        pos_y      <= y;
        cell_index <= idx;
        @(negedge clk);
        while (!in_taken) @(negedge clk);
        req_count[rq]++;
        sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send(REQ_PUT, b, 8'($urandom), 8'($urandom), 11'($urandom));
    endtask

    task automatic set_cursor(input logic [7:0] x, input logic [7:0] y);
        send(REQ_CURSOR, 8'($urandom), x, y, 11'($urandom));
    endtask

    task automatic clear_screen();
        send(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 11'($urandom));
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_col();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'($urandom_range(0, COLUMNS - 1));
        if (r < 9) return 8'($urandom_range(COLUMNS - 5, COLUMNS - 1));
        return 8'($urandom_range(COLUMNS, 255));
    endfunction

    function automatic logic [7:0] pick_row();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'($urandom_range(0, ROWS - 1));
        if (r < 9) return 8'($urandom_range(ROWS - 2, ROWS - 1));
        return 8'($urandom_range(ROWS, 255));
    endfunction

    function automatic logic [10:0] pick_cell();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 11'($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
        if (r < 9) return 11'($urandom_range(0, CELLS - 1));
        return 11'($urandom_range(CELLS, 2047));
    endfunction

    initial begin
        int first_random;
        int kind;
        int run_len;
        logic [7:0] esc_code;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, buffer ends and reads past the end
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'h7FF);
        put_byte(8'h41);
        put_byte(8'hFF);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(CH_ESC_ATTR);
        put_byte(8'hA5);
        put_byte(CH_ESC_FG);
        put_byte(8'hF3);
        put_byte(CH_ESC_BG);
        put_byte(8'h0C);
        // escape left pending across other requests
        put_byte(CH_ESC_ATTR);
        read_cell(11'd1);
        set_cursor(8'd3, 8'd1);
        put_byte(8'h3C);
        // wrap at the last cell, then out-of-range cursor axes
        set_cursor(8'(COLUMNS - 1), 8'(ROWS - 1));
        put_byte(8'h5A);
        set_cursor(8'hFF, 8'hFF);
        set_cursor(8'(COLUMNS), 8'(ROWS));
        read_cell(11'(CELLS - COLUMNS - 1));
        put_byte(CH_LF);
        clear_screen();
        read_cell(11'd0);

        drain_results();

        first_random = sent;
        while (sent - first_random < 1000) begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                run_len = $urandom_range(1, 12);
                repeat (run_len) put_byte(8'($urandom_range(32, 126)));
            end else if (kind < 50) begin
                if ($urandom_range(0, 1) == 0) put_byte(CH_CR);
                put_byte(CH_LF);
            end else if (kind < 62) begin
                case ($urandom_range(0, 2))
                    0: esc_code = CH_ESC_ATTR;
                    1: esc_code = CH_ESC_FG;
                    default: esc_code = CH_ESC_BG;
                endcase
                put_byte(esc_code);
                put_byte(8'($urandom_range(0, 255)));
            end else if (kind < 70) begin
                set_cursor(pick_col(), pick_row());
            end else if (kind < 88) begin
                read_cell(pick_cell());
            end else if (kind < 90) begin
                clear_screen();
            end else if (kind < 95) begin
                // broken sequence: escape interrupted by another request
                put_byte(8'(CH_ESC_FG + $urandom_range(0, 1) - $urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 0) read_cell(pick_cell());
                else set_cursor(pick_col(), pick_row());
                put_byte(8'($urandom_range(0, 255)));
            end else begin
                put_byte(8'($urandom_range(0, 255)));
            end
        end

        drain_results();
        repeat (10) @(negedge clk);

        $display("run covered %0d items: %0d puts, %0d cursor moves, %0d clears, %0d reads",
                 sent, req_count[REQ_PUT], req_count[REQ_CURSOR], req_count[REQ_CLEAR],
                 req_count[REQ_READ]);
        $display("%0d results compared, %0d scrolls predicted", checked, scrolls);
        if (fail_count == 0 && pending == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("%0t: timed out with %0d results outstanding", $time, pending);
        $display("** text_console_writer: FAILED **");
        $finish;
    end

endmodule

FILE: text_console_writer.f
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_dpath.sv
src/text_console_writer.sv
test/text_console_checker.sv
test/testbench.sv
